// File: rtl/nps_pkg.sv
// Shared types and constants for the nine-patch rectangle splitter.
// Used by the front end, divider, queue, back end and top level; no dependencies.
package nps_pkg;

  localparam int SRC_W         = 13;                    // source pixel coordinates
  localparam int Q_W           = 24;                    // signed fixed-point destination
  localparam int PATCHES       = 3;                     // patches per axis
  localparam int LINES         = PATCHES + 1;           // cut lines per axis
  localparam int PROD_W        = SRC_W + Q_W;           // |span| * margin
  localparam int DIV_STEP_BITS = 4;                     // quotient bits per divider cycle
  localparam int DIV_CYCLES    = Q_W / DIV_STEP_BITS;
  localparam int QUEUE_DEPTH   = 2;

  typedef logic [SRC_W-1:0]        src_t;
  typedef logic signed [Q_W-1:0]   q_t;

  // One fully resolved item: cut lines for both axes, ready to be split.
  typedef struct packed {
    logic                ok;
    src_t [LINES-1:0]    sx;
    src_t [LINES-1:0]    sy;
    q_t   [LINES-1:0]    dx;
    q_t   [LINES-1:0]    dy;
  } nps_item_t;

  typedef struct packed {
    logic                load;
    logic [PROD_W-1:0]   dividend;
    src_t                divisor;
  } nps_div_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } nps_q_stat_t;

endpackage

// File: rtl/nps_div.sv
// Unsigned radix-16 restoring divider for the collapse point of one axis.
// Depends on nps_pkg. The quotient is known to fit in Q_W bits.
module nps_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nps_pkg::nps_div_req_t req,
  output logic                 done,
  output logic [nps_pkg::Q_W-1:0] quotient
);
  import nps_pkg::*;

  localparam int CNT_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  logic              run_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  src_t              rem_r;
  src_t              den_r;
  logic [Q_W-1:0]    quo_r;
  src_t              rem_nxt;
  logic [Q_W-1:0]    quo_nxt;
  logic [SRC_W:0]    shifted;

  // The dividend's low bits shift out of quo_r as quotient bits shift in.
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    shifted = '0;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      shifted = {rem_nxt, quo_nxt[Q_W-1]};
      quo_nxt = {quo_nxt[Q_W-2:0], 1'b0};
      if (shifted >= {1'b0, den_r}) begin
        shifted    = shifted - {1'b0, den_r};
        quo_nxt[0] = 1'b1;
      end
      rem_nxt = shifted[SRC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= run_r && !req.load && (cnt_r == CNT_W'(DIV_CYCLES - 1));
      if (req.load) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_CYCLES - 1)) begin
          run_r <= 1'b0;
        end
      end
    end
    if (req.load) begin
      rem_r <= req.dividend[PROD_W-1:Q_W];
      quo_r <= req.dividend[Q_W-1:0];
      den_r <= req.divisor;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/nps_front.sv
// Front end: takes an item, checks it, builds the cut lines of both axes and,
// where an axis collapses, runs the multiply and divide. Depends on nps_pkg, nps_div.
module nps_front #(
  parameter int MAX_IMAGE_SIZE = 4096,
  parameter int FRAC_BITS      = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  nps_pkg::src_t        in_image_width,
  input  nps_pkg::src_t        in_image_height,
  input  nps_pkg::src_t        in_center_left,
  input  nps_pkg::src_t        in_center_top,
  input  nps_pkg::src_t        in_center_right,
  input  nps_pkg::src_t        in_center_bottom,
  input  nps_pkg::q_t          in_dest_left,
  input  nps_pkg::q_t          in_dest_top,
  input  nps_pkg::q_t          in_dest_right,
  input  nps_pkg::q_t          in_dest_bottom,
  output logic                 busy,
  output logic                 push,
  output nps_pkg::nps_item_t   push_item,
  input  nps_pkg::nps_q_stat_t q_stat
);
  import nps_pkg::*;

  localparam int LW_A = Q_W + 1;
  localparam int LW_B = SRC_W + FRAC_BITS + 1;
  localparam int LW   = ((LW_A > LW_B) ? LW_A : LW_B) + 1;
  localparam int SZ_W = 17;
  localparam logic [SZ_W-1:0] MAX_SZ = SZ_W'(MAX_IMAGE_SIZE);

  typedef logic signed [LW-1:0] wide_t;

  localparam wide_t Q_MAX_W = wide_t'((64'sd1 <<< (Q_W - 1)) - 64'sd1);
  localparam wide_t Q_MIN_W = wide_t'(-(64'sd1 <<< (Q_W - 1)));

  typedef struct packed {
    q_t             l1;
    q_t             l2;
    logic           collapse;
    logic           neg;
    logic [Q_W-1:0] mag;
    src_t           lo;
    src_t           den;
  } axis_t;

  typedef enum logic [2:0] {
    F_EMPTY,
    F_MUL,
    F_LOAD,
    F_WAIT,
    F_FIN,
    F_READY
  } fstate_t;

  function automatic q_t sat_q(wide_t v);
    q_t r;
    if (v > Q_MAX_W) begin
      r = Q_MAX_W[Q_W-1:0];
    end else if (v < Q_MIN_W) begin
      r = Q_MIN_W[Q_W-1:0];
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic axis_t axis_cut(q_t d0, q_t d3, src_t size, src_t lo, src_t hi);
    axis_t                a;
    src_t                 m_hi;
    wide_t                s1;
    wide_t                s2;
    logic signed [Q_W:0]  diff;
    m_hi       = size - hi;
    s1         = wide_t'(d0) + (wide_t'(lo) <<< FRAC_BITS);
    s2         = wide_t'(d3) - (wide_t'(m_hi) <<< FRAC_BITS);
    a.l1       = sat_q(s1);
    a.l2       = sat_q(s2);
    a.collapse = $signed(a.l1) > $signed(a.l2);
    diff       = (Q_W+1)'(d3) - (Q_W+1)'(d0);
    a.neg      = diff[Q_W];
    a.mag      = diff[Q_W] ? Q_W'(-diff) : Q_W'(diff);
    a.lo       = lo;
    a.den      = lo + m_hi;
    return a;
  endfunction

  fstate_t           state_r;
  fstate_t           state_nxt;
  nps_item_t         item_r;
  nps_item_t         item_nxt;
  axis_t             ax_r;
  axis_t             ay_r;
  axis_t             axn;
  axis_t             ayn;
  logic [PROD_W-1:0] prod_x_r;
  logic [PROD_W-1:0] prod_y_r;
  logic              ok;
  logic              need_div;
  logic              load;
  nps_div_req_t      req_x;
  nps_div_req_t      req_y;
  logic              done_x;
  logic              done_y;
  logic [Q_W-1:0]    quo_x;
  logic [Q_W-1:0]    quo_y;
  q_t                mid_x;
  q_t                mid_y;
  wide_t             qs_x;
  wide_t             qs_y;

  assign push = (state_r == F_READY) && !q_stat.full;
  assign busy = !((state_r == F_EMPTY) || push);
  assign load = start && !busy;

  always_comb begin
    ok = (in_center_left < in_center_right) && (in_center_top < in_center_bottom) &&
         (in_center_right <= in_image_width) && (in_center_bottom <= in_image_height) &&
         (SZ_W'(in_image_width) <= MAX_SZ) && (SZ_W'(in_image_height) <= MAX_SZ);
    axn = axis_cut(in_dest_left, in_dest_right, in_image_width,
                   in_center_left, in_center_right);
    ayn = axis_cut(in_dest_top, in_dest_bottom, in_image_height,
                   in_center_top, in_center_bottom);
    need_div = ok && (axn.collapse || ayn.collapse);

    item_nxt       = '0;
    item_nxt.ok    = ok;
    item_nxt.sx[0] = '0;
    item_nxt.sx[1] = in_center_left;
    item_nxt.sx[2] = in_center_right;
    item_nxt.sx[3] = in_image_width;
    item_nxt.sy[0] = '0;
    item_nxt.sy[1] = in_center_top;
    item_nxt.sy[2] = in_center_bottom;
    item_nxt.sy[3] = in_image_height;
    item_nxt.dx[0] = in_dest_left;
    item_nxt.dx[1] = axn.l1;
    item_nxt.dx[2] = axn.l2;
    item_nxt.dx[3] = in_dest_right;
    item_nxt.dy[0] = in_dest_top;
    item_nxt.dy[1] = ayn.l1;
    item_nxt.dy[2] = ayn.l2;
    item_nxt.dy[3] = in_dest_bottom;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_EMPTY: begin
        if (start) begin
          state_nxt = need_div ? F_MUL : F_READY;
        end
      end
      F_MUL:  state_nxt = F_LOAD;
      F_LOAD: state_nxt = F_WAIT;
      F_WAIT: begin
        if (done_x && done_y) begin
          state_nxt = F_FIN;
        end
      end
      F_FIN:  state_nxt = F_READY;
      F_READY: begin
        if (push) begin
          if (start) begin
            state_nxt = need_div ? F_MUL : F_READY;
          end else begin
            state_nxt = F_EMPTY;
          end
        end
      end
      default: state_nxt = F_EMPTY;
    endcase
  end

  // Collapse point: edge0 plus the signed, truncated quotient; a zero
  // margin sum pins both inner lines to edge0.
  always_comb begin
    qs_x  = ax_r.neg ? -wide_t'(quo_x) : wide_t'(quo_x);
    qs_y  = ay_r.neg ? -wide_t'(quo_y) : wide_t'(quo_y);
    mid_x = (ax_r.den == '0) ? item_r.dx[0] :
            sat_q(wide_t'($signed(item_r.dx[0])) + qs_x);
    mid_y = (ay_r.den == '0) ? item_r.dy[0] :
            sat_q(wide_t'($signed(item_r.dy[0])) + qs_y);
  end

  always_comb begin
    req_x.load     = (state_r == F_LOAD);
    req_x.dividend = prod_x_r;
    req_x.divisor  = ax_r.den;
    req_y.load     = (state_r == F_LOAD);
    req_y.dividend = prod_y_r;
    req_y.divisor  = ay_r.den;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_EMPTY;
    end else begin
      state_r <= state_nxt;
    end
    if (load) begin
      item_r <= item_nxt;
      ax_r   <= axn;
      ay_r   <= ayn;
    end
    if (state_r == F_MUL) begin
      prod_x_r <= PROD_W'(ax_r.mag) * PROD_W'(ax_r.lo);
      prod_y_r <= PROD_W'(ay_r.mag) * PROD_W'(ay_r.lo);
    end
    if (state_r == F_FIN) begin
      if (ax_r.collapse) begin
        item_r.dx[1] <= mid_x;
        item_r.dx[2] <= mid_x;
      end
      if (ay_r.collapse) begin
        item_r.dy[1] <= mid_y;
        item_r.dy[2] <= mid_y;
      end
    end
  end

  nps_div u_div_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_x),
    .done     (done_x),
    .quotient (quo_x)
  );

  nps_div u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_y),
    .done     (done_y),
    .quotient (quo_y)
  );

  assign push_item = item_r;

endmodule

// File: rtl/nps_queue.sv
// Short FIFO of resolved items between the front end and the back end.
// Depends on nps_pkg.
module nps_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  nps_pkg::nps_item_t   push_item,
  input  logic                 pop,
  output nps_pkg::nps_item_t   head,
  output nps_pkg::nps_q_stat_t stat
);
  import nps_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] n;
    n = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

  nps_item_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= next_ptr(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= next_ptr(rd_ptr_r);
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// File: rtl/nps_back.sv
// Back end: walks a valid head item's nine patches in row-major order, one
// beat per cycle while queued, and pops it with its last. Depends on nps_pkg.
module nps_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nps_pkg::nps_item_t   head,
  input  nps_pkg::nps_q_stat_t q_stat,
  output logic                 pop,
  output logic                 out_strobe,
  output logic                 out_valid_res,
  output nps_pkg::src_t        out_src_left,
  output nps_pkg::src_t        out_src_top,
  output nps_pkg::src_t        out_src_right,
  output nps_pkg::src_t        out_src_bottom,
  output nps_pkg::q_t          out_left,
  output nps_pkg::q_t          out_top,
  output nps_pkg::q_t          out_right,
  output nps_pkg::q_t          out_bottom,
  output logic                 out_last
);
  import nps_pkg::*;

  localparam int IDX_W = $clog2(LINES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PATCHES - 1);

  logic [IDX_W-1:0] col_r;
  logic [IDX_W-1:0] row_r;
  logic [IDX_W-1:0] col_p1;
  logic [IDX_W-1:0] row_p1;
  logic             emit;
  logic             is_last;
  logic             strobe_r;
  logic             valid_r;
  logic             last_r;
  src_t             sl_r;
  src_t             st_r;
  src_t             sr_r;
  src_t             sb_r;
  q_t               dl_r;
  q_t               dt_r;
  q_t               dr_r;
  q_t               db_r;

  assign col_p1  = col_r + 1'b1;
  assign row_p1  = row_r + 1'b1;
  assign emit    = !q_stat.empty;
  // A rejected item produces a single beat, which is also its last.
  assign is_last = !head.ok || ((col_r == LAST_IDX) && (row_r == LAST_IDX));
  assign pop     = emit && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      strobe_r <= emit;
      if (emit) begin
        if (is_last) begin
          col_r <= '0;
          row_r <= '0;
        end else if (col_r == LAST_IDX) begin
          col_r <= '0;
          row_r <= row_p1;
        end else begin
          col_r <= col_p1;
        end
      end
    end
    if (emit) begin
      valid_r <= head.ok;
      last_r  <= is_last;
      sl_r    <= head.ok ? head.sx[col_r]  : '0;
      st_r    <= head.ok ? head.sy[row_r]  : '0;
      sr_r    <= head.ok ? head.sx[col_p1] : '0;
      sb_r    <= head.ok ? head.sy[row_p1] : '0;
      dl_r    <= head.ok ? head.dx[col_r]  : '0;
      dt_r    <= head.ok ? head.dy[row_r]  : '0;
      dr_r    <= head.ok ? head.dx[col_p1] : '0;
      db_r    <= head.ok ? head.dy[row_p1] : '0;
    end
  end

  assign out_strobe     = strobe_r;
  assign out_valid_res  = valid_r;
  assign out_src_left   = sl_r;
  assign out_src_top    = st_r;
  assign out_src_right  = sr_r;
  assign out_src_bottom = sb_r;
  assign out_left       = dl_r;
  assign out_top        = dt_r;
  assign out_right      = dr_r;
  assign out_bottom     = db_r;
  assign out_last       = last_r;

endmodule

// File: rtl/nine_patch_rect_splitter.sv
// Top level of the nine-patch rectangle splitter.
// Depends on nps_pkg, nps_front, nps_queue, nps_back (and nps_div below the front end).

// An item is taken on a rising edge with start high and busy low. A valid
// item yields nine result beats in row-major order (out_last on the ninth), an
// invalid one a single beat with out_valid_res low and out_last high; each
// beat sits on the out_ ports for exactly one cycle under out_strobe and
// cannot be held off. Without a collapse the front end takes one item per
// cycle while the queue has room; each item passes the front end's item
// register, the queue and the back end's output registers, and the result
// port sets the sustained rate: nine beats per valid item, one rejected item
// per cycle. An axis that collapses adds a multiply, a divider load, a
// radix-16 divide and a finishing step in the front end, which takes no new
// item until the collapsing item is pushed; the two-entry queue ahead of the
// result port absorbs such items when they arrive among ordinary ones.
module nine_patch_rect_splitter #(
  parameter int MAX_IMAGE_SIZE = 4096,
  parameter int FRAC_BITS      = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  nps_pkg::src_t in_image_width,
  input  nps_pkg::src_t in_image_height,
  input  nps_pkg::src_t in_center_left,
  input  nps_pkg::src_t in_center_top,
  input  nps_pkg::src_t in_center_right,
  input  nps_pkg::src_t in_center_bottom,
  input  nps_pkg::q_t   in_dest_left,
  input  nps_pkg::q_t   in_dest_top,
  input  nps_pkg::q_t   in_dest_right,
  input  nps_pkg::q_t   in_dest_bottom,
  output logic          out_strobe,
  output logic          out_valid_res,
  output nps_pkg::src_t out_src_left,
  output nps_pkg::src_t out_src_top,
  output nps_pkg::src_t out_src_right,
  output nps_pkg::src_t out_src_bottom,
  output nps_pkg::q_t   out_left,
  output nps_pkg::q_t   out_top,
  output nps_pkg::q_t   out_right,
  output nps_pkg::q_t   out_bottom,
  output logic          out_last
);
  import nps_pkg::*;

  logic        q_push;
  logic        q_pop;
  nps_item_t   q_in;
  nps_item_t   q_head;
  nps_q_stat_t q_stat;

  nps_front #(
    .MAX_IMAGE_SIZE (MAX_IMAGE_SIZE),
    .FRAC_BITS      (FRAC_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_image_width   (in_image_width),
    .in_image_height  (in_image_height),
    .in_center_left   (in_center_left),
    .in_center_top    (in_center_top),
    .in_center_right  (in_center_right),
    .in_center_bottom (in_center_bottom),
    .in_dest_left     (in_dest_left),
    .in_dest_top      (in_dest_top),
    .in_dest_right    (in_dest_right),
    .in_dest_bottom   (in_dest_bottom),
    .busy             (busy),
    .push             (q_push),
    .push_item        (q_in),
    .q_stat           (q_stat)
  );

  nps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  nps_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .q_stat         (q_stat),
    .pop            (q_pop),
    .out_strobe     (out_strobe),
    .out_valid_res  (out_valid_res),
    .out_src_left   (out_src_left),
    .out_src_top    (out_src_top),
    .out_src_right  (out_src_right),
    .out_src_bottom (out_src_bottom),
    .out_left       (out_left),
    .out_top        (out_top),
    .out_right      (out_right),
    .out_bottom     (out_bottom),
    .out_last       (out_last)
  );

  a_queue_no_overflow: assert property (
    @(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full
  ) else $error("item pushed into a full queue");

  a_queue_no_underflow: assert property (
    @(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty
  ) else $error("item popped from an empty queue");

  a_reject_is_last: assert property (
    @(posedge clk) disable iff (!rst_n) (out_strobe && !out_valid_res) |-> out_last
  ) else $error("rejection beat without last");

  a_patches_unbroken: assert property (
    @(posedge clk) disable iff (!rst_n)
      (out_strobe && out_valid_res && !out_last) |=> (out_strobe && out_valid_res)
  ) else $error("patch sequence broken before its last beat");

endmodule

// File: test/tb_nine_patch_rect_splitter.sv
// Self-checking testbench for nine_patch_rect_splitter: a directed table, then random items.
// Depends on nps_pkg and the RTL; expected patches come from a predictor kept in this file.
module tb_nine_patch_rect_splitter;
  import nps_pkg::*;

  localparam int IMG_MAX        = 4096;
  localparam int FRAC_BITS      = 8;
  localparam longint Q_HI       = 64'sd8388607;
  localparam longint Q_LO       = -64'sd8388608;
  localparam int RANDOM_ITEMS   = 408;
  localparam int CALM_TAIL      = 60;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DIRECTED_COUNT = 22;

  typedef struct packed {
    src_t img_w;
    src_t img_h;
    src_t c_left;
    src_t c_top;
    src_t c_right;
    src_t c_bottom;
    q_t   d_left;
    q_t   d_top;
    q_t   d_right;
    q_t   d_bottom;
    logic reject_known;
  } stim_row_t;

  typedef struct packed {
    logic valid_res;
    src_t src_left;
    src_t src_top;
    src_t src_right;
    src_t src_bottom;
    q_t   left;
    q_t   top;
    q_t   right;
    q_t   bottom;
    logic last;
  } patch_t;

  typedef struct packed {
    q_t d0;
    q_t d3;
  } span_t;

  typedef q_t [LINES-1:0] cuts_t;
  typedef src_t [LINES-1:0] src_cuts_t;

  typedef enum {DM_RANDOM, DM_ROOMY, DM_TIGHT, DM_REVERSED, DM_HIGH, DM_LOW} dest_mode_t;
  typedef enum {F_EMPTY, F_SWAPPED, F_PAST_EDGE, F_OVERSIZE, F_NOISE} fault_t;

  localparam patch_t REJECT_BEAT = '{valid_res: 1'b0, last: 1'b1, default: '0};

  // Rows flagged in the last column expect a single rejection beat, typed in here.
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{100, 80, 10, 10, 90, 70, 0, 0, 51200, 40960, 1'b0},
    '{1, 1, 0, 0, 1, 1, 0, 0, 256, 256, 1'b0},
    '{4096, 4096, 0, 0, 4096, 4096, -8388608, -8388608, 8388607, 8388607, 1'b0},
    '{4096, 4096, 1, 1, 4095, 4095, -8388608, 8388607, 8388607, -8388608, 1'b0},
    '{100, 100, 40, 40, 60, 60, 0, 0, 2560, 2560, 1'b0},
    '{64, 48, 10, 30, 20, 40, -5000, -3000, -4000, -2900, 1'b0},
    '{50, 50, 0, 0, 50, 50, 1000, 1000, -1000, -1000, 1'b0},
    '{200, 200, 150, 150, 160, 160, 8388507, 8388507, 8388607, 8388607, 1'b0},
    '{200, 200, 5, 5, 10, 10, -8388608, -8388608, -8388508, -8388508, 1'b0},
    '{30, 30, 7, 0, 9, 30, 300, 0, -301, 500, 1'b0},
    '{4096, 1, 4095, 0, 4096, 1, 0, 0, 1048576, 256, 1'b0},
    '{13, 13, 5, 5, 8, 8, 5592405, -5592406, -5592406, 5592405, 1'b0},
    '{10, 10, 3, 3, 7, 7, 2560, 2560, 2560, 2560, 1'b0},
    '{100, 100, 50, 10, 50, 90, 0, 0, 25600, 25600, 1'b1},
    '{100, 100, 10, 60, 90, 40, 0, 0, 25600, 25600, 1'b1},
    '{100, 100, 10, 10, 101, 90, 0, 0, 25600, 25600, 1'b1},
    '{100, 100, 10, 10, 90, 101, 0, 0, 25600, 25600, 1'b1},
    '{4097, 100, 10, 10, 90, 90, 0, 0, 25600, 25600, 1'b1},
    '{100, 8191, 10, 10, 90, 90, 0, 0, 25600, 25600, 1'b1},
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1},
    '{8191, 8191, 8191, 8191, 8191, 8191, -1, -1, -1, -1, 1'b1},
    '{4096, 4096, 0, 0, 4096, 4097, 0, 0, 0, 0, 1'b1}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  stim_row_t cur_item = '0;

  logic busy;
  logic out_strobe;
  logic out_valid_res;
  logic out_last;
  src_t out_src_left;
  src_t out_src_top;
  src_t out_src_right;
  src_t out_src_bottom;
  q_t   out_left;
  q_t   out_top;
  q_t   out_right;
  q_t   out_bottom;

  patch_t pending_patches[$];
  int     mismatches = 0;
  int     cycle_count = 0;

  always #5 clk = ~clk;

  nine_patch_rect_splitter DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_image_width   (cur_item.img_w),
    .in_image_height  (cur_item.img_h),
    .in_center_left   (cur_item.c_left),
    .in_center_top    (cur_item.c_top),
    .in_center_right  (cur_item.c_right),
    .in_center_bottom (cur_item.c_bottom),
    .in_dest_left     (cur_item.d_left),
    .in_dest_top      (cur_item.d_top),
    .in_dest_right    (cur_item.d_right),
    .in_dest_bottom   (cur_item.d_bottom),
    .out_strobe       (out_strobe),
    .out_valid_res    (out_valid_res),
    .out_src_left     (out_src_left),
    .out_src_top      (out_src_top),
    .out_src_right    (out_src_right),
    .out_src_bottom   (out_src_bottom),
    .out_left         (out_left),
    .out_top          (out_top),
    .out_right        (out_right),
    .out_bottom       (out_bottom),
    .out_last         (out_last)
  );

  function automatic longint clamp_q(longint v);
    if (v > Q_HI) begin
      return Q_HI;
    end
    if (v < Q_LO) begin
      return Q_LO;
    end
    return v;
  endfunction

  // Destination cut lines of one axis. When the inner lines cross, both move to
  // one point placed in proportion to the two source margins.
  function automatic cuts_t dest_cuts(q_t d0, q_t d3, src_t size, src_t lo, src_t hi);
    cuts_t  c;
    longint e0, e3, m_lo, m_hi, l1, l2, den, mid;
    e0   = longint'(d0);
    e3   = longint'(d3);
    m_lo = longint'(lo);
    m_hi = longint'(size) - longint'(hi);
    l1   = clamp_q(e0 + m_lo * (64'sd1 <<< FRAC_BITS));
    l2   = clamp_q(e3 - m_hi * (64'sd1 <<< FRAC_BITS));
    if (l1 > l2) begin
      den = m_lo + m_hi;
      mid = e0;
      if (den > 0) begin
        mid = clamp_q(e0 + ((e3 - e0) * m_lo) / den);
      end
      l1 = mid;
      l2 = mid;
    end
    c[0] = d0;
    c[1] = q_t'(l1);
    c[2] = q_t'(l2);
    c[3] = d3;
    return c;
  endfunction

  // Queues the patches that one accepted item must produce.
  function automatic void split_item(stim_row_t it);
    cuts_t     dxc, dyc;
    src_cuts_t sxc, syc;
    patch_t    p;
    logic      ok;
    ok = (it.c_left < it.c_right) && (it.c_top < it.c_bottom) &&
         (it.c_right <= it.img_w) && (it.c_bottom <= it.img_h) &&
         (it.img_w <= IMG_MAX) && (it.img_h <= IMG_MAX);
    if (!ok) begin
      pending_patches.push_back(REJECT_BEAT);
    end else begin
      sxc = {it.img_w, it.c_right, it.c_left, src_t'(0)};
      syc = {it.img_h, it.c_bottom, it.c_top, src_t'(0)};
      dxc = dest_cuts(it.d_left, it.d_right, it.img_w, it.c_left, it.c_right);
      dyc = dest_cuts(it.d_top, it.d_bottom, it.img_h, it.c_top, it.c_bottom);
      for (int j = 0; j < PATCHES; j++) begin
        for (int i = 0; i < PATCHES; i++) begin
          p.valid_res  = 1'b1;
          p.src_left   = sxc[i];
          p.src_top    = syc[j];
          p.src_right  = sxc[i+1];
          p.src_bottom = syc[j+1];
          p.left       = dxc[i];
          p.top        = dyc[j];
          p.right      = dxc[i+1];
          p.bottom     = dyc[j+1];
          p.last       = (i == PATCHES - 1) && (j == PATCHES - 1);
          pending_patches.push_back(p);
        end
      end
    end
  endfunction

  function automatic longint pick_size();
    case ($urandom_range(9, 0))
      0:       return IMG_MAX;
      1, 2, 3: return $urandom_range(16, 1);
      4, 5, 6: return $urandom_range(300, 1);
      default: return $urandom_range(IMG_MAX, 1);
    endcase
  endfunction

  function automatic span_t random_span(longint size, longint lo, longint hi);
    span_t      s;
    dest_mode_t mode;
    longint     d0, d3, margins;
    margins = (lo + size - hi) * (64'sd1 <<< FRAC_BITS);
    case ($urandom_range(9, 0))
      0:       mode = DM_RANDOM;
      1, 2, 3: mode = DM_ROOMY;
      4, 5:    mode = DM_TIGHT;
      6:       mode = DM_REVERSED;
      7:       mode = DM_HIGH;
      8:       mode = DM_LOW;
      default: mode = DM_TIGHT;
    endcase
    d0 = longint'($urandom_range(1 << 23, 0)) - (64'sd1 <<< 22);
    d3 = d0;
    case (mode)
      DM_RANDOM: begin
        d0 = longint'(q_t'($urandom));
        d3 = longint'(q_t'($urandom));
      end
      DM_ROOMY:    d3 = d0 + margins + $urandom_range(1 << 16, 0);
      DM_TIGHT:    d3 = d0 + $urandom_range(margins, 0);
      DM_REVERSED: d3 = d0 - $urandom_range(1 << 20, 0);
      DM_HIGH: begin
        d3 = Q_HI - $urandom_range(255, 0);
        d0 = d3 - $urandom_range(margins + 512, 0);
      end
      DM_LOW: begin
        d0 = Q_LO + $urandom_range(255, 0);
        d3 = d0 + $urandom_range(margins + 512, 0);
      end
      default: d3 = d0;
    endcase
    s.d0 = q_t'(clamp_q(d0));
    s.d3 = q_t'(clamp_q(d3));
    return s;
  endfunction

  // Mostly well-formed items with random content; about one in seven is broken.
  function automatic stim_row_t random_item();
    stim_row_t it;
    span_t     sx, sy;
    longint    w, h;
    src_t      tmp;
    fault_t    fault;
    it = '0;
    w = pick_size();
    h = pick_size();
    it.img_w = src_t'(w);
    it.img_h = src_t'(h);
    if ($urandom_range(9, 0) == 0) begin
      it.c_left  = '0;
      it.c_right = src_t'(w);
    end else begin
      it.c_left  = src_t'($urandom_range(w - 1, 0));
      it.c_right = src_t'($urandom_range(w, it.c_left + 1));
    end
    if ($urandom_range(9, 0) == 0) begin
      it.c_top    = '0;
      it.c_bottom = src_t'(h);
    end else begin
      it.c_top    = src_t'($urandom_range(h - 1, 0));
      it.c_bottom = src_t'($urandom_range(h, it.c_top + 1));
    end
    sx = random_span(w, it.c_left, it.c_right);
    sy = random_span(h, it.c_top, it.c_bottom);
    it.d_left   = sx.d0;
    it.d_right  = sx.d3;
    it.d_top    = sy.d0;
    it.d_bottom = sy.d3;
    if ($urandom_range(99, 0) < 15) begin
      fault = fault_t'($urandom_range(F_NOISE, F_EMPTY));
      case (fault)
        F_EMPTY: begin
          if ($urandom_range(1, 0)) it.c_right = it.c_left;
          else it.c_bottom = it.c_top;
        end
        F_SWAPPED: begin
          tmp         = it.c_left;
          it.c_left   = it.c_right;
          it.c_right  = tmp;
        end
        F_PAST_EDGE: begin
          if ($urandom_range(1, 0)) it.c_right = src_t'($urandom_range(8191, w + 1));
          else it.c_bottom = src_t'($urandom_range(8191, h + 1));
        end
        F_OVERSIZE: begin
          if ($urandom_range(1, 0)) it.img_w = src_t'($urandom_range(8191, IMG_MAX + 1));
          else it.img_h = src_t'($urandom_range(8191, IMG_MAX + 1));
        end
        default: begin
          it.img_w    = src_t'($urandom);
          it.img_h    = src_t'($urandom);
          it.c_left   = src_t'($urandom);
          it.c_top    = src_t'($urandom);
          it.c_right  = src_t'($urandom);
          it.c_bottom = src_t'($urandom);
          it.d_left   = q_t'($urandom);
          it.d_top    = q_t'($urandom);
          it.d_right  = q_t'($urandom);
          it.d_bottom = q_t'($urandom);
        end
      endcase
    end
    return it;
  endfunction

  task automatic check_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Predicts at the edge that accepts an item and checks every result beat.
  always @(posedge clk) begin
    patch_t want, got;
    if (rst_n) begin
      if (start && !busy) begin
        if (cur_item.reject_known) pending_patches.push_back(REJECT_BEAT);
        else split_item(cur_item);
      end
      if (out_strobe) begin
        got = '{out_valid_res, out_src_left, out_src_top, out_src_right, out_src_bottom,
                out_left, out_top, out_right, out_bottom, out_last};
        if (pending_patches.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual valid_res=%0b last=%0b",
                   $time, got.valid_res, got.last);
          mismatches++;
        end else begin
          want = pending_patches.pop_front();
          check_field("valid_res", want.valid_res, got.valid_res);
          check_field("src_left", want.src_left, got.src_left);
          check_field("src_top", want.src_top, got.src_top);
          check_field("src_right", want.src_right, got.src_right);
          check_field("src_bottom", want.src_bottom, got.src_bottom);
          check_field("out_left", $signed(want.left), $signed(got.left));
          check_field("out_top", $signed(want.top), $signed(got.top));
          check_field("out_right", $signed(want.right), $signed(got.right));
          check_field("out_bottom", $signed(want.bottom), $signed(got.bottom));
          check_field("last", want.last, got.last);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats still expected", $time, pending_patches.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Holds the item on the ports until the block takes it.
  task automatic send_item(stim_row_t it);
    cur_item <= it;
    start    <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(99, 0) < idle_pct) return $urandom_range(17, 1);
    return 0;
  endfunction

  initial begin
    int idle_pct;
    idle_pct = 20;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      idle_for(pick_gap(idle_pct));
      send_item(DIRECTED_ROWS[r]);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2, 0))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (n < RANDOM_ITEMS - CALM_TAIL) idle_for(pick_gap(idle_pct));
      send_item(random_item());
    end
    start <= 1'b0;
    while (pending_patches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: nine_patch_rect_splitter.f
rtl/nps_pkg.sv
rtl/nps_div.sv
rtl/nps_front.sv
rtl/nps_queue.sv
rtl/nps_back.sv
rtl/nine_patch_rect_splitter.sv
test/tb_nine_patch_rect_splitter.sv
